FILE: src/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Shared constants, codes and types of the sorted value table.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

  localparam int DEPTH         = 16;
  localparam int VALUE_W       = 32;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int ENTRY_COUNT_W = 5;
  localparam int STATUS_W      = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request
    logic compare;  // register per-cell compare flags
    logic apply;    // shift cells, update count, register the result
  } svt_cmd_t;

endpackage

`default_nettype wire

FILE: src/svt_ctrl.sv
// ----------------------------------------------------------------------------
// svt_ctrl
// Request sequencer: load, compare, apply, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_ctrl
  import svt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  output svt_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // A new item may enter while the previous result is on the ports.
  assign busy      = (state_r == ST_CMP) || (state_r == ST_APPLY);
  assign out_valid = (state_r == ST_RESP);
  assign accept    = start && !busy;

  assign cmd.load    = accept;
  assign cmd.compare = (state_r == ST_CMP);
  assign cmd.apply   = (state_r == ST_APPLY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_RESP;
      ST_RESP:  state_nxt = accept ? ST_CMP : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/svt_datapath.sv
// ----------------------------------------------------------------------------
// svt_datapath
// Row of entry cells with parallel compare and one-step shift.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_datapath
  import svt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire svt_cmd_t                 cmd,
  input  wire logic                     in_req_type,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic [ENTRY_COUNT_W-1:0]      out_entry_count,
  output logic [STATUS_W-1:0]           out_status
);

  logic               req_r;
  value_t             value_r;
  value_t             entries_r   [DEPTH];
  value_t             entries_nxt [DEPTH];
  count_t             count_r;
  count_t             count_nxt;
  logic [DEPTH-1:0]   lt_r;
  logic [DEPTH-1:0]   lt_nxt;
  logic [DEPTH-1:0]   shift_r;
  logic [DEPTH-1:0]   shift_nxt;
  logic               found_r;
  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   eq_vec;
  logic [DEPTH-1:0]   first_eq;
  logic               full;
  logic [STATUS_W-1:0] status_nxt;
  logic [ENTRY_COUNT_W-1:0] out_count_r;
  logic [STATUS_W-1:0] out_status_r;

  assign full = (count_r == count_t'(DEPTH));

  // Per-cell compare against the request value; only filled cells count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i]  = (count_t'(i) < count_r);
      lt_nxt[i] = valid[i] && (entries_r[i] < value_r);
      eq_vec[i] = valid[i] && (entries_r[i] == value_r);
    end
    // Isolate the lowest match, then mark it and every cell above it.
    first_eq  = eq_vec & (~eq_vec + 1'b1);
    shift_nxt = ~(first_eq - 1'b1);
  end

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    status_nxt  = STATUS_DONE;
    if (req_r == REQ_INSERT) begin
      if (full) begin
        status_nxt = STATUS_FULL;
      end else begin
        // Cells below the slot hold, the slot takes the value, cells above move up.
        if (!lt_r[0]) entries_nxt[0] = value_r;
        for (int i = 1; i < DEPTH; i++) begin
          if (!lt_r[i]) begin
            entries_nxt[i] = lt_r[i-1] ? value_r : entries_r[i-1];
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (!found_r) begin
        status_nxt = STATUS_NOT_FOUND;
      end else begin
        // Close the gap: cells from the match upward take their upper neighbor.
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (shift_r[i]) entries_nxt[i] = entries_r[i+1];
        end
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      value_r <= in_value;
    end
    if (cmd.compare) begin
      lt_r    <= lt_nxt;
      shift_r <= shift_nxt;
      found_r <= |eq_vec;
    end
    if (cmd.apply) begin
      entries_r    <= entries_nxt;
      out_count_r  <= ENTRY_COUNT_W'(count_nxt);
      out_status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

FILE: src/sorted_value_table.sv
// ----------------------------------------------------------------------------
// sorted_value_table
// Bounded table of signed values kept in ascending order, with in-order
// insert and first-match remove; every request answers with count and status.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------
//   request  | in_req_type, in_value                   | start & !busy
//   result   | out_entry_count, out_status             | out_valid, 1 cycle
//
// Each request passes through capture, parallel compare across all cells,
// then shift-and-write; the result strobe follows and a new request may be
// taken in that same strobe cycle. Reset is synchronous and active low; it
// empties the table (count to zero). The result cannot be stalled: out_valid
// is high for exactly one cycle per request.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_value_table
  import svt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_req_type,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  output logic [ENTRY_COUNT_W-1:0]       out_entry_count,
  output logic [STATUS_W-1:0]            out_status
);

  svt_cmd_t cmd;

  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  svt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
